/* design/assert_macros.svh */
// Assertion macros shared by the ALU/register file executor.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define RFA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("rfa assertion failed");

// Expression must never be true outside reset.
`define RFA_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("rfa forbidden condition seen");

`endif

/* design/rfa_pkg.sv */
// Shared types and constants for the ALU/register file executor.
// No dependencies; imported by every module of the block.
package rfa_pkg;

  localparam int FUNC_W       = 4;
  localparam int REG_IDX_W    = 5;
  localparam int IMM_W        = 32;
  localparam int DATA_W       = 64;
  localparam int HALF_W       = 32;
  localparam int DEF_NUM_REGS = 32;

  // stream payload layout
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 72;
  localparam int IN_FUNC_LSB = 0;
  localparam int IN_DEST_LSB = IN_FUNC_LSB + FUNC_W;
  localparam int IN_SRCA_LSB = IN_DEST_LSB + REG_IDX_W;
  localparam int IN_SRCB_LSB = IN_SRCA_LSB + REG_IDX_W;
  localparam int IN_IMM_LSB  = IN_SRCB_LSB + REG_IDX_W;
  localparam int OUT_REG_LSB = 0;
  localparam int OUT_VAL_LSB = OUT_REG_LSB + REG_IDX_W;

  typedef enum logic [FUNC_W-1:0] {
    OP_NOP     = 4'd0,
    OP_SET     = 4'd1,
    OP_ADD32I  = 4'd2,
    OP_ADD32R  = 4'd3,
    OP_SUB32I  = 4'd4,
    OP_SUB32R  = 4'd5,
    OP_ADD64I  = 4'd6,
    OP_ADD64IT = 4'd7,
    OP_OR32R   = 4'd8,
    OP_XOR32R  = 4'd9,
    OP_AND64I  = 4'd10,
    OP_OR64I   = 4'd11,
    OP_XOR64I  = 4'd12
  } op_t;

  // ALU outcome handed to the result stage
  typedef struct packed {
    logic              wr;
    logic [DATA_W-1:0] value;
  } alu_res_t;

endpackage

/* design/register_file_alu_executor.sv */
// Integer ALU with a 64-bit register file, streaming in and out.
// Input transfer (in_tdata): one operation - opcode, destination, two
// sources, 32-bit immediate. Output transfer: one report per operation,
// out_tuser = write flag, out_tdata = written register index and the full
// 64-bit register value after the write (zeros for nop / unused opcodes).
// Pipeline: the accepting edge captures the operands from the register
// file (with bypass of the write landing on that same edge) into the
// execute stage; the ALU result goes into the output register and the
// register file when the execute stage moves on, which waits while the
// output register holds an untaken report; out_tvalid then rises. While
// out_tready stays high, throughput is one operation per cycle, set by
// the read-modify-write of the register file.
// Register indexes wrap modulo NUM_REGS before use and in the report.
// Reset (rst_n low, synchronous) empties both stages and clears every
// entry's valid bit, so all registers read as zero right after reset.
// When out_tready is low the output register holds its report; the execute
// stage can still take one more operation, then in_tready drops until the
// output drains.
// Depends on rfa_pkg, rfa_regfile, rfa_alu and assert_macros.svh.
module register_file_alu_executor #(
  parameter int NUM_REGS = rfa_pkg::DEF_NUM_REGS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // in_tdata: func[3:0], dest_reg[8:4], src_a_reg[13:9], src_b_reg[18:14],
  //           immediate[50:19], zero pad[55:51]
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [rfa_pkg::IN_TDATA_W-1:0] in_tdata,
  // out_tdata: written_reg[4:0], written_value[68:5], zero pad[71:69]
  // out_tuser: write_valid[0]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [rfa_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic [0:0]                      out_tuser
);
  import rfa_pkg::*;

  `include "assert_macros.svh"

  localparam int IW = $clog2(NUM_REGS);

  // index wrap table, built at elaboration
  logic [IW-1:0] wrap_tbl [2**REG_IDX_W];
  for (genvar g = 0; g < 2**REG_IDX_W; g++) begin : g_wrap
    assign wrap_tbl[g] = IW'(g % NUM_REGS);
  end

  logic                 in_xfer;
  logic [IW-1:0]        in_dest, in_srca, in_srcb;

  // execute stage
  logic                 s1_valid_r, s1_valid_nxt;
  op_t                  s1_func_r;
  logic [IW-1:0]        s1_dest_r;
  logic [IMM_W-1:0]     s1_imm_r;
  logic                 s1_move;

  // output register
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_wv_r;
  logic [REG_IDX_W-1:0] out_reg_r;
  logic [DATA_W-1:0]    out_val_r;

  logic [DATA_W-1:0]    op_a;
  logic [HALF_W-1:0]    op_b_lo, old_d_hi;
  alu_res_t             alu_res;
  logic                 rf_wr_en;

  assign in_dest = wrap_tbl[in_tdata[IN_DEST_LSB +: REG_IDX_W]];
  assign in_srca = wrap_tbl[in_tdata[IN_SRCA_LSB +: REG_IDX_W]];
  assign in_srcb = wrap_tbl[in_tdata[IN_SRCB_LSB +: REG_IDX_W]];

  // handshake: execute stage advances whenever the output slot is free
  assign s1_move   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_move;
  assign in_xfer   = in_tvalid && in_tready;
  assign rf_wr_en  = s1_move && alu_res.wr;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_move) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_func_r <= op_t'(in_tdata[IN_FUNC_LSB +: FUNC_W]);
      s1_dest_r <= in_dest;
      s1_imm_r  <= in_tdata[IN_IMM_LSB +: IMM_W];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_wv_r  <= alu_res.wr;
      out_reg_r <= alu_res.wr ? REG_IDX_W'(s1_dest_r) : '0;
      out_val_r <= alu_res.value;
    end
  end

  rfa_regfile #(
    .NUM_REGS (NUM_REGS)
  ) u_regfile (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (in_xfer),
    .rd_a_addr (in_srca),
    .rd_b_addr (in_srcb),
    .rd_d_addr (in_dest),
    .wr_en     (rf_wr_en),
    .wr_addr   (s1_dest_r),
    .wr_data   (alu_res.value),
    .op_a      (op_a),
    .op_b_lo   (op_b_lo),
    .old_d_hi  (old_d_hi)
  );

  rfa_alu u_alu (
    .func     (s1_func_r),
    .imm      (s1_imm_r),
    .op_a     (op_a),
    .op_b_lo  (op_b_lo),
    .old_d_hi (old_d_hi),
    .res      (alu_res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_wv_r;
  assign out_tdata  = {{(OUT_TDATA_W-REG_IDX_W-DATA_W){1'b0}}, out_val_r, out_reg_r};

  // a no-write report carries all-zero payload
  `RFA_ASSERT(a_nop_zero, clk, rst_n, (out_valid_r && !out_wv_r) |-> (out_tdata == '0))
  // an empty execute stage never blocks the input
  `RFA_ASSERT(a_empty_ready, clk, rst_n, !s1_valid_r |-> in_tready)
  // every register file write shows up as a write report on the next edge
  `RFA_ASSERT(a_wr_reported, clk, rst_n, rf_wr_en |=> (out_valid_r && out_wv_r))
  // reported register index always within the file
  `RFA_ASSERT_NEVER(a_reg_range, clk, rst_n, out_valid_r && (int'(out_reg_r) >= NUM_REGS))

endmodule

/* design/rfa_regfile.sv */
// Register file: low and high 32-bit halves, each one write and two reads,
// registered read data with write bypass, per-entry valid bits. Uses rfa_pkg.
module rfa_regfile #(
  parameter int NUM_REGS = rfa_pkg::DEF_NUM_REGS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        rd_en,
  input  logic [$clog2(NUM_REGS)-1:0] rd_a_addr,
  input  logic [$clog2(NUM_REGS)-1:0] rd_b_addr,
  input  logic [$clog2(NUM_REGS)-1:0] rd_d_addr,
  input  logic                        wr_en,
  input  logic [$clog2(NUM_REGS)-1:0] wr_addr,
  input  logic [rfa_pkg::DATA_W-1:0]  wr_data,
  output logic [rfa_pkg::DATA_W-1:0]  op_a,
  output logic [rfa_pkg::HALF_W-1:0]  op_b_lo,
  output logic [rfa_pkg::HALF_W-1:0]  old_d_hi
);
  import rfa_pkg::*;

  logic [HALF_W-1:0] mem_lo [NUM_REGS];  // read at a and b
  logic [HALF_W-1:0] mem_hi [NUM_REGS];  // read at a and d
  logic [NUM_REGS-1:0] valid_r;

  logic [HALF_W-1:0] a_lo_r, a_hi_r, b_lo_r, d_hi_r;
  logic              a_ok_r, b_ok_r, d_ok_r;
  logic              hit_a, hit_b, hit_d;

  assign hit_a = wr_en && (wr_addr == rd_a_addr);
  assign hit_b = wr_en && (wr_addr == rd_b_addr);
  assign hit_d = wr_en && (wr_addr == rd_d_addr);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_lo[wr_addr] <= wr_data[HALF_W-1:0];
      mem_hi[wr_addr] <= wr_data[DATA_W-1:HALF_W];
    end
  end

  // registered reads; a same-edge write is bypassed
  always_ff @(posedge clk) begin
    if (rd_en) begin
      a_lo_r <= hit_a ? wr_data[HALF_W-1:0]      : mem_lo[rd_a_addr];
      a_hi_r <= hit_a ? wr_data[DATA_W-1:HALF_W] : mem_hi[rd_a_addr];
      b_lo_r <= hit_b ? wr_data[HALF_W-1:0]      : mem_lo[rd_b_addr];
      d_hi_r <= hit_d ? wr_data[DATA_W-1:HALF_W] : mem_hi[rd_d_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      a_ok_r  <= 1'b0;
      b_ok_r  <= 1'b0;
      d_ok_r  <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        a_ok_r <= hit_a || valid_r[rd_a_addr];
        b_ok_r <= hit_b || valid_r[rd_b_addr];
        d_ok_r <= hit_d || valid_r[rd_d_addr];
      end
    end
  end

  // never-written entries read as zero
  assign op_a     = a_ok_r ? {a_hi_r, a_lo_r} : '0;
  assign op_b_lo  = b_ok_r ? b_lo_r : '0;
  assign old_d_hi = d_ok_r ? d_hi_r : '0;

endmodule

/* design/rfa_alu.sv */
// Integer ALU: computes the new destination value for one operation.
// Uses rfa_pkg (op_t, alu_res_t).
module rfa_alu (
  input  rfa_pkg::op_t                func,
  input  logic [rfa_pkg::IMM_W-1:0]   imm,
  input  logic [rfa_pkg::DATA_W-1:0]  op_a,
  input  logic [rfa_pkg::HALF_W-1:0]  op_b_lo,
  input  logic [rfa_pkg::HALF_W-1:0]  old_d_hi,
  output rfa_pkg::alu_res_t           res
);
  import rfa_pkg::*;

  logic [DATA_W-1:0] imm_sx;
  logic [DATA_W-1:0] sum64;
  logic [HALF_W-1:0] a_lo;

  assign a_lo   = op_a[HALF_W-1:0];
  assign imm_sx = {{(DATA_W-IMM_W){imm[IMM_W-1]}}, imm};
  assign sum64  = op_a + imm_sx;

  always_comb begin
    res.wr    = 1'b1;
    res.value = '0;
    unique case (func)
      OP_SET:     res.value = imm_sx;
      OP_ADD32I:  res.value = {old_d_hi, a_lo + imm};
      OP_ADD32R:  res.value = {old_d_hi, a_lo + op_b_lo};
      OP_SUB32I:  res.value = {old_d_hi, a_lo - imm};
      OP_SUB32R:  res.value = {old_d_hi, a_lo - op_b_lo};
      OP_ADD64I:  res.value = sum64;
      OP_ADD64IT: res.value = {{HALF_W{sum64[HALF_W-1]}}, sum64[HALF_W-1:0]};
      OP_OR32R:   res.value = {old_d_hi, a_lo | op_b_lo};
      OP_XOR32R:  res.value = {old_d_hi, a_lo ^ op_b_lo};
      OP_AND64I:  res.value = {{HALF_W{1'b0}}, a_lo & imm};
      OP_OR64I:   res.value = {op_a[DATA_W-1:HALF_W], a_lo | imm};
      OP_XOR64I:  res.value = {op_a[DATA_W-1:HALF_W], a_lo ^ imm};
      default: begin
        // nop and unused codes: no write, zero report
        res.wr    = 1'b0;
        res.value = '0;
      end
    endcase
  end

endmodule
